// File: hw/rtl/cna_pkg.sv
package cna_pkg;

    // operand and result format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // action codes
    localparam logic [2:0] ACT_ADD  = 3'd0;
    localparam logic [2:0] ACT_SUB  = 3'd1;
    localparam logic [2:0] ACT_MUL  = 3'd2;
    localparam logic [2:0] ACT_DIV  = 3'd3;
    localparam logic [2:0] ACT_MAG  = 3'd4;
    localparam logic [2:0] ACT_CONJ = 3'd5;

    // input transaction
    typedef struct packed {
        logic [2:0]                   action;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_real;
        logic signed [DATA_WIDTH-1:0] res_imag;
        logic                         zero_divisor;
        logic                         overflowed;
    } t_out_item;

    // magnitude limits of the signed result range
    localparam logic [2*DATA_WIDTH-1:0] MAG_NEG_MAX =
        (2*DATA_WIDTH)'(1) << (DATA_WIDTH-1);
    localparam logic [2*DATA_WIDTH-1:0] MAG_POS_MAX = MAG_NEG_MAX - (2*DATA_WIDTH)'(1);

    // sign-magnitude to two's complement with clamping, returns {overflow, value}
    function automatic logic [DATA_WIDTH:0] saturate(
        input logic                    neg,
        input logic [2*DATA_WIDTH-1:0] mag,
        input logic                    force_sat
    );
        logic [2*DATA_WIDTH-1:0] lim;
        logic                    over;
        logic [DATA_WIDTH-1:0]   val;
        lim  = neg ? MAG_NEG_MAX : MAG_POS_MAX;
        over = force_sat | (mag > lim);
        val  = over ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        if (neg) begin
            val = -val;
        end
        return {over, val};
    endfunction

endpackage

// File: hw/rtl/cna_div.sv
module cna_div #(
    parameter int WIDTH = cna_pkg::DATA_WIDTH,
    parameter int FRAC  = cna_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic [2*WIDTH-1:0]   i_num,
    input  logic [2*WIDTH-1:0]   i_den,
    output logic [WIDTH+1:0]     o_quo,
    output logic                 o_big
);

    localparam int NW    = 2*WIDTH;
    localparam int STEPS = NW + FRAC;
    localparam int RW    = NW + 1;
    localparam int QW    = WIDTH + 1;

    logic [NW-1:0] r_num [0:STEPS-1];
    logic [NW-1:0] r_den [0:STEPS-1];
    logic [RW-1:0] r_rem [0:STEPS-1];
    logic [QW-1:0] r_quo [0:STEPS-1];
    logic          r_big [0:STEPS-1];
    logic [QW:0]   r_quo_out;
    logic          r_big_out;

    // one restoring quotient bit per stage, numerator scaled by 2^FRAC
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [NW-1:0] num_in;
        logic [NW-1:0] den_in;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic          big_in;
        logic          bit_in;
        logic [RW-1:0] rem_sh;
        logic          fits;

        if (g == 0) begin : g_first
            assign num_in = i_num;
            assign den_in = i_den;
            assign rem_in = '0;
            assign quo_in = '0;
            assign big_in = 1'b0;
        end else begin : g_next
            assign num_in = r_num[g-1];
            assign den_in = r_den[g-1];
            assign rem_in = r_rem[g-1];
            assign quo_in = r_quo[g-1];
            assign big_in = r_big[g-1];
        end

        // scaling zeros follow the numerator bits
        if (g < NW) begin : g_num_bit
            assign bit_in = num_in[NW-1-g];
        end else begin : g_zero_bit
            assign bit_in = 1'b0;
        end

        assign rem_sh = {rem_in[RW-2:0], bit_in};
        assign fits   = rem_sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_num[g] <= num_in;
            r_den[g] <= den_in;
            r_rem[g] <= fits ? rem_sh - {1'b0, den_in} : rem_sh;
            r_quo[g] <= {quo_in[QW-2:0], fits};
            r_big[g] <= big_in | quo_in[QW-1];
        end
    end

    // round half away from zero on the magnitude
    always_ff @(posedge i_clk) begin
        r_quo_out <= {1'b0, r_quo[STEPS-1]}
                   + (QW+1)'({r_rem[STEPS-1][RW-2:0], 1'b0} >= {1'b0, r_den[STEPS-1]});
        r_big_out <= r_big[STEPS-1];
    end

    assign o_quo = r_quo_out;
    assign o_big = r_big_out;

endmodule

// File: hw/rtl/cna_sqrt.sv
module cna_sqrt #(
    parameter int WIDTH = cna_pkg::DATA_WIDTH
) (
    input  logic                 i_clk,
    input  logic [2*WIDTH-1:0]   i_sum,
    output logic [WIDTH:0]       o_root
);

    localparam int NW    = 2*WIDTH;
    localparam int STEPS = WIDTH;
    localparam int RW    = WIDTH + 2;

    logic [NW-1:0]    r_sum  [0:STEPS-1];
    logic [RW-1:0]    r_rem  [0:STEPS-1];
    logic [WIDTH-1:0] r_root [0:STEPS-1];
    logic [WIDTH:0]   r_root_out;

    // one root bit per stage from two radicand bits
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [NW-1:0]    sum_in;
        logic [RW-1:0]    rem_in;
        logic [WIDTH-1:0] root_in;
        logic [RW+1:0]    rem_sh;
        logic [RW+1:0]    trial;
        logic             fits;

        if (g == 0) begin : g_first
            assign sum_in  = i_sum;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign sum_in  = r_sum[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        assign rem_sh = {rem_in, sum_in[NW-1-2*g -: 2]};
        assign trial  = (RW+2)'({root_in, 2'b01});
        assign fits   = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            r_sum[g]  <= sum_in;
            r_rem[g]  <= RW'(fits ? rem_sh - trial : rem_sh);
            r_root[g] <= {root_in[WIDTH-2:0], fits};
        end
    end

    // round to nearest: remainder above the root means the next half is passed
    always_ff @(posedge i_clk) begin
        r_root_out <= (WIDTH+1)'(r_root[STEPS-1])
                    + (WIDTH+1)'(r_rem[STEPS-1] > RW'(r_root[STEPS-1]));
    end

    assign o_root = r_root_out;

endmodule

// File: hw/rtl/complex_number_alu_core.sv
// channel   | ports                          | handshake
// ----------+--------------------------------+------------------------------------
// operands  | start, busy, i_operands        | taken on a clock edge with start=1, busy=0
// result    | o_res_valid, o_result          | one cycle per result, no back-pressure
//
// one transaction is taken every clock cycle; busy stays low
// each result's delay is set by the bit-per-stage quotient pipeline, whose depth follows
// the operand format (Q16.16 here); side data and the root are delayed to line up with it
// the result side cannot stall, so nothing is ever held back
// reset clears the valid bits only; data stages run freely
module complex_number_alu_core #(
    parameter int FRAC_BITS = cna_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cna_pkg::t_in_item  i_operands,
    output logic               o_res_valid,
    output cna_pkg::t_out_item o_result
);

    localparam int W     = cna_pkg::DATA_WIDTH;
    localparam int LW    = W + 1;
    localparam int NW    = 2*W;
    localparam int MW    = 2*W + 1;
    localparam int STEPS = NW + FRAC_BITS;
    localparam int RDLY  = STEPS - W;
    localparam logic [NW-1:0] HALF_LSB = NW'(1) << (FRAC_BITS-1);

    typedef struct packed {
        logic [2:0]    action;
        logic          zdiv;
        logic          nre_neg;
        logic          nim_neg;
        logic          re_neg;
        logic          im_neg;
        logic [NW-1:0] re_mag;
        logic [NW-1:0] im_mag;
    } t_side;

    function automatic logic [NW-1:0] abs_wide(input logic signed [MW-1:0] x);
        return NW'(x[MW-1] ? -x : x);
    endfunction

    logic signed [W-1:0]  ar, ai, br, bi;
    logic signed [LW-1:0] lin_re, lin_im;

    logic                 r_s1_vld;
    logic [2:0]           r_s1_action;
    logic signed [NW-1:0] r_s1_p_rr, r_s1_p_ii, r_s1_p_ri, r_s1_p_ir;
    logic [NW-1:0]        r_s1_q_ar, r_s1_q_ai, r_s1_q_br, r_s1_q_bi;
    logic signed [LW-1:0] r_s1_lin_re, r_s1_lin_im;

    logic                 r_s2_vld;
    logic [2:0]           r_s2_action;
    logic signed [MW-1:0] r_s2_mre, r_s2_mim, r_s2_nre, r_s2_nim;
    logic [NW-1:0]        r_s2_den, r_s2_sum;
    logic signed [LW-1:0] r_s2_lin_re, r_s2_lin_im;

    logic                 r_s3_vld;
    logic [2:0]           r_s3_action;
    logic                 r_s3_mre_neg, r_s3_mim_neg, r_s3_nre_neg, r_s3_nim_neg;
    logic [NW-1:0]        r_s3_mre_mag, r_s3_mim_mag, r_s3_nre_mag, r_s3_nim_mag;
    logic [NW-1:0]        r_s3_den, r_s3_sum;
    logic                 r_s3_lre_neg, r_s3_lim_neg;
    logic [LW-1:0]        r_s3_lre_mag, r_s3_lim_mag;
    logic                 r_s3_zdiv;

    t_side                n_side;
    t_side                r_side_dly [0:STEPS];
    logic [STEPS:0]       r_vld_dly;
    logic [W:0]           root;
    logic [W:0]           r_root_dly [0:RDLY-1];
    logic [W+1:0]         quo_re, quo_im;
    logic                 big_re, big_im;

    t_side                side;
    logic [W:0]           sat_re, sat_im;
    logic                 zdiv;
    cna_pkg::t_out_item   n_result;
    cna_pkg::t_out_item   r_result;
    logic                 r_res_valid;

    assign busy = 1'b0;

    assign ar = i_operands.a_real;
    assign ai = i_operands.a_imag;
    assign br = i_operands.b_real;
    assign bi = i_operands.b_imag;

    // sum, difference and conjugate need no multiplier
    always_comb begin
        lin_re = '0;
        lin_im = '0;
        case (i_operands.action)
            cna_pkg::ACT_ADD: begin
                lin_re = LW'(ar) + LW'(br);
                lin_im = LW'(ai) + LW'(bi);
            end
            cna_pkg::ACT_SUB: begin
                lin_re = LW'(ar) - LW'(br);
                lin_im = LW'(ai) - LW'(bi);
            end
            cna_pkg::ACT_CONJ: begin
                lin_re = LW'(ar);
                lin_im = -LW'(ai);
            end
            default: ;
        endcase
    end

    // stage 1: cross products and squares
    always_ff @(posedge i_clk) begin
        r_s1_action <= i_operands.action;
        r_s1_p_rr   <= ar * br;
        r_s1_p_ii   <= ai * bi;
        r_s1_p_ri   <= ar * bi;
        r_s1_p_ir   <= ai * br;
        r_s1_q_ar   <= ar * ar;
        r_s1_q_ai   <= ai * ai;
        r_s1_q_br   <= br * br;
        r_s1_q_bi   <= bi * bi;
        r_s1_lin_re <= lin_re;
        r_s1_lin_im <= lin_im;
    end

    // stage 2: product parts, quotient numerators, divisor and magnitude radicand
    always_ff @(posedge i_clk) begin
        r_s2_action <= r_s1_action;
        r_s2_mre    <= MW'(r_s1_p_rr) - MW'(r_s1_p_ii);
        r_s2_mim    <= MW'(r_s1_p_ri) + MW'(r_s1_p_ir);
        r_s2_nre    <= MW'(r_s1_p_rr) + MW'(r_s1_p_ii);
        r_s2_nim    <= MW'(r_s1_p_ir) - MW'(r_s1_p_ri);
        r_s2_den    <= r_s1_q_br + r_s1_q_bi;
        r_s2_sum    <= r_s1_q_ar + r_s1_q_ai;
        r_s2_lin_re <= r_s1_lin_re;
        r_s2_lin_im <= r_s1_lin_im;
    end

    // stage 3: split into sign and magnitude
    always_ff @(posedge i_clk) begin
        r_s3_action  <= r_s2_action;
        r_s3_mre_neg <= r_s2_mre[MW-1];
        r_s3_mim_neg <= r_s2_mim[MW-1];
        r_s3_nre_neg <= r_s2_nre[MW-1];
        r_s3_nim_neg <= r_s2_nim[MW-1];
        r_s3_mre_mag <= abs_wide(r_s2_mre);
        r_s3_mim_mag <= abs_wide(r_s2_mim);
        r_s3_nre_mag <= abs_wide(r_s2_nre);
        r_s3_nim_mag <= abs_wide(r_s2_nim);
        r_s3_den     <= r_s2_den;
        r_s3_sum     <= r_s2_sum;
        r_s3_lre_neg <= r_s2_lin_re[LW-1];
        r_s3_lim_neg <= r_s2_lin_im[LW-1];
        r_s3_lre_mag <= r_s2_lin_re[LW-1] ? -r_s2_lin_re : r_s2_lin_re;
        r_s3_lim_mag <= r_s2_lin_im[LW-1] ? -r_s2_lin_im : r_s2_lin_im;
        r_s3_zdiv    <= (r_s2_den == '0);
    end

    // stage 4: rounded product or plain sum, difference or conjugate, plus what the late stage needs
    always_comb begin
        n_side         = '0;
        n_side.action  = r_s3_action;
        n_side.zdiv    = r_s3_zdiv;
        n_side.nre_neg = r_s3_nre_neg;
        n_side.nim_neg = r_s3_nim_neg;
        if (r_s3_action == cna_pkg::ACT_MUL) begin
            n_side.re_neg = r_s3_mre_neg;
            n_side.im_neg = r_s3_mim_neg;
            n_side.re_mag = (r_s3_mre_mag + HALF_LSB) >> FRAC_BITS;
            n_side.im_mag = (r_s3_mim_mag + HALF_LSB) >> FRAC_BITS;
        end else begin
            n_side.re_neg = r_s3_lre_neg;
            n_side.im_neg = r_s3_lim_neg;
            n_side.re_mag = NW'(r_s3_lre_mag);
            n_side.im_mag = NW'(r_s3_lim_mag);
        end
    end

    // side data rides alongside the quotient pipeline
    always_ff @(posedge i_clk) begin
        r_side_dly[0] <= n_side;
        for (int k = 1; k <= STEPS; k++) begin
            r_side_dly[k] <= r_side_dly[k-1];
        end
    end

    // valid bits for every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_vld_dly <= '0;
        end else begin
            r_s1_vld  <= start & ~busy;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_vld_dly <= {r_vld_dly[STEPS-1:0], r_s3_vld};
        end
    end

    // quotient lanes share the divisor
    cna_div #(
        .WIDTH (W),
        .FRAC  (FRAC_BITS)
    ) u_div_re (
        .i_clk (i_clk),
        .i_num (r_s3_nre_mag),
        .i_den (r_s3_den),
        .o_quo (quo_re),
        .o_big (big_re)
    );

    cna_div #(
        .WIDTH (W),
        .FRAC  (FRAC_BITS)
    ) u_div_im (
        .i_clk (i_clk),
        .i_num (r_s3_nim_mag),
        .i_den (r_s3_den),
        .o_quo (quo_im),
        .o_big (big_im)
    );

    cna_sqrt #(
        .WIDTH (W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_sum  (r_s3_sum),
        .o_root (root)
    );

    // root is ready early, delay it to line up with the quotient
    always_ff @(posedge i_clk) begin
        r_root_dly[0] <= root;
        for (int k = 1; k < RDLY; k++) begin
            r_root_dly[k] <= r_root_dly[k-1];
        end
    end

    assign side = r_side_dly[STEPS];

    // final select, clamp to range
    always_comb begin
        sat_re = '0;
        sat_im = '0;
        zdiv   = 1'b0;
        case (side.action)
            cna_pkg::ACT_ADD, cna_pkg::ACT_SUB, cna_pkg::ACT_MUL, cna_pkg::ACT_CONJ: begin
                sat_re = cna_pkg::saturate(side.re_neg, side.re_mag, 1'b0);
                sat_im = cna_pkg::saturate(side.im_neg, side.im_mag, 1'b0);
            end
            cna_pkg::ACT_DIV: begin
                if (side.zdiv) begin
                    zdiv = 1'b1;
                end else begin
                    sat_re = cna_pkg::saturate(side.nre_neg, NW'(quo_re), big_re);
                    sat_im = cna_pkg::saturate(side.nim_neg, NW'(quo_im), big_im);
                end
            end
            cna_pkg::ACT_MAG: begin
                sat_re = cna_pkg::saturate(1'b0, NW'(r_root_dly[RDLY-1]), 1'b0);
            end
            default: ;
        endcase
        n_result.res_real     = sat_re[W-1:0];
        n_result.res_imag     = sat_im[W-1:0];
        n_result.zero_divisor = zdiv;
        n_result.overflowed   = sat_re[W] | sat_im[W];
    end

    // output register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_vld_dly[STEPS];
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

// File: tb/complex_number_alu_checker.sv
// watches both channels, predicts each result and compares it with the block
module complex_number_alu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  cna_pkg::t_in_item  i_operands,
    input  logic               i_res_valid,
    input  cna_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cna_pkg::*;

    t_out_item awaited_results[$];

    // clamp a sign-magnitude value to the signed range, flag any clipping
    function automatic logic [DATA_WIDTH-1:0] clamp_part(
        input logic neg,
        input logic [127:0] mag,
        input logic force_sat,
        inout logic ovf
    );
        logic [127:0] lim;
        logic [DATA_WIDTH-1:0] val;
        lim = neg ? (128'd1 << (DATA_WIDTH - 1)) : ((128'd1 << (DATA_WIDTH - 1)) - 1);
        if (force_sat || mag > lim) begin
            ovf = 1'b1;
            mag = lim;
        end
        val = mag[DATA_WIDTH-1:0];
        return neg ? -val : val;
    endfunction

    function automatic logic [127:0] magnitude_of(input logic signed [129:0] v);
        logic signed [129:0] a;
        a = v[129] ? -v : v;
        return a[127:0];
    endfunction

    // exact value divided by 2^FRAC_BITS, ties away from zero
    function automatic logic [127:0] round_frac(input logic [127:0] mag);
        return (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    // num * 2^FRAC_BITS / den rounded to nearest, ties away from zero
    function automatic logic [127:0] scaled_quotient(
        input logic [127:0] num,
        input logic [127:0] den
    );
        logic [127:0] q;
        logic [127:0] rm;
        q  = (num << FRAC_BITS) / den;
        rm = (num << FRAC_BITS) % den;
        if ((rm << 1) >= den) begin
            q = q + 1;
        end
        return q;
    endfunction

    // integer square root rounded to nearest
    function automatic logic [127:0] rounded_sqrt(input logic [127:0] s);
        logic [127:0] root;
        logic [127:0] bitv;
        logic [127:0] t;
        root = '0;
        bitv = 128'd1 << 126;
        while (bitv > s) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            t = root + bitv;
            if (s >= t) begin
                s    = s - t;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (s > root) begin
            root = root + 1;
        end
        return root;
    endfunction

    function automatic t_out_item complex_result(input t_in_item x);
        logic signed [129:0] ar;
        logic signed [129:0] ai;
        logic signed [129:0] br;
        logic signed [129:0] bi;
        logic signed [129:0] pr;
        logic signed [129:0] pi;
        logic [127:0] den;
        logic ovf;
        t_out_item y;
        ar  = $signed(x.a_real);
        ai  = $signed(x.a_imag);
        br  = $signed(x.b_real);
        bi  = $signed(x.b_imag);
        y   = '0;
        ovf = 1'b0;
        case (x.action)
            ACT_ADD: begin
                pr = ar + br;
                pi = ai + bi;
                y.res_real = clamp_part(pr[129], magnitude_of(pr), 1'b0, ovf);
                y.res_imag = clamp_part(pi[129], magnitude_of(pi), 1'b0, ovf);
            end
            ACT_SUB: begin
                pr = ar - br;
                pi = ai - bi;
                y.res_real = clamp_part(pr[129], magnitude_of(pr), 1'b0, ovf);
                y.res_imag = clamp_part(pi[129], magnitude_of(pi), 1'b0, ovf);
            end
            ACT_MUL: begin
                pr = ar * br - ai * bi;
                pi = ar * bi + ai * br;
                y.res_real = clamp_part(pr[129], round_frac(magnitude_of(pr)), 1'b0, ovf);
                y.res_imag = clamp_part(pi[129], round_frac(magnitude_of(pi)), 1'b0, ovf);
            end
            ACT_DIV: begin
                pr  = br * br + bi * bi;
                den = pr[127:0];
                if (den == 0) begin
                    y.zero_divisor = 1'b1;
                end else begin
                    pr = ar * br + ai * bi;
                    pi = ai * br - ar * bi;
                    y.res_real = clamp_part(pr[129],
                        scaled_quotient(magnitude_of(pr), den), 1'b0, ovf);
                    y.res_imag = clamp_part(pi[129],
                        scaled_quotient(magnitude_of(pi), den), 1'b0, ovf);
                end
            end
            ACT_MAG: begin
                pr = ar * ar + ai * ai;
                y.res_real = clamp_part(1'b0, rounded_sqrt(pr[127:0]), 1'b0, ovf);
            end
            ACT_CONJ: begin
                pi = -ai;
                y.res_real = x.a_real;
                y.res_imag = clamp_part(pi[129], magnitude_of(pi), 1'b0, ovf);
            end
            default: begin
            end
        endcase
        y.overflowed = ovf;
        return y;
    endfunction

    assign o_pending = awaited_results.size();

    // predict on each accepted transaction, compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_start && !i_busy) begin
                awaited_results.push_back(complex_result(i_operands));
            end
            if (i_res_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_result.res_real !== want.res_real)
                            $error("res_real: expected %h, got %h",
                                   want.res_real, i_result.res_real);
                        if (i_result.res_imag !== want.res_imag)
                            $error("res_imag: expected %h, got %h",
                                   want.res_imag, i_result.res_imag);
                        if (i_result.zero_divisor !== want.zero_divisor)
                            $error("zero_divisor: expected %b, got %b",
                                   want.zero_divisor, i_result.zero_divisor);
                        if (i_result.overflowed !== want.overflowed)
                            $error("overflowed: expected %b, got %b",
                                   want.overflowed, i_result.overflowed);
                    end
                end
            end
        end
    end

endmodule

// File: tb/complex_number_alu_core_test.sv
module complex_number_alu_core_test;
    import cna_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_operands;
    logic      o_res_valid;
    t_out_item o_result;
    int        fail_count;
    int        pending;
    int        idle_pct;
    int        quiet_cycles;

    complex_number_alu_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operands (i_operands),
        .o_res_valid(o_res_valid),
        .o_result   (o_result)
    );

    complex_number_alu_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_operands  (i_operands),
        .i_res_valid (o_res_valid),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on cycles with no transaction moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** complex_number_alu_core: FAILED **");
                $finish;
            end
        end
    end

    // operand part: mostly full range, some small, some at the extremes
    function automatic logic [DATA_WIDTH-1:0] pick_part();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return $urandom;
        if (sel < 8) return DATA_WIDTH'($signed($urandom_range(1 << 21)) - (1 << 20));
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0001;
            default: return '0;
        endcase
    endfunction

    // send one transaction, idling first at the phase rate
    task automatic issue(input t_in_item x);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start      <= 1'b1;
        i_operands <= x;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic issue_fields(input logic [2:0] act, input logic [31:0] ar,
                                input logic [31:0] ai, input logic [31:0] br,
                                input logic [31:0] bi);
        t_in_item x;
        x = '{act, ar, ai, br, bi};
        issue(x);
    endtask

    initial begin
        t_in_item x;
        int phase_pct[4];
        phase_pct = '{0, 51, 0, 9};
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_operands = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every action, range extremes, divide by zero, rounding ties
        issue_fields(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
        issue_fields(ACT_ADD, 32'h0001_0000, 32'hfffe_0000, 32'h0002_8000, 32'h0000_4000);
        issue_fields(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
        issue_fields(ACT_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
        issue_fields(ACT_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
        issue_fields(ACT_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
        issue_fields(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        issue_fields(ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        issue_fields(ACT_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hffff_0000);
        issue_fields(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
        issue_fields(ACT_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        issue_fields(ACT_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        issue_fields(ACT_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
        issue_fields(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        issue_fields(ACT_DIV, 32'h0005_0000, 32'hfffb_0000, 32'h0001_0000, 32'h0002_0000);
        issue_fields(ACT_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        issue_fields(ACT_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h1234_5678, 32'h0000_0000);
        issue_fields(ACT_MAG, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        issue_fields(ACT_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        issue_fields(ACT_CONJ, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        issue_fields(3'd6, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 32'h0000_0001);
        issue_fields(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);

        // random transactions over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_pct[ph];
            for (int n = 0; n < 210; n++) begin
                x.action = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                     : 3'($urandom_range(5));
                x.a_real = pick_part();
                x.a_imag = pick_part();
                x.b_real = pick_part();
                x.b_imag = pick_part();
                if (x.action == ACT_DIV && $urandom_range(9) == 0) begin
                    x.b_real = '0;
                    x.b_imag = '0;
                end
                issue(x);
            end
        end
        start <= 1'b0;

        // drain outstanding results, then allow for the pipeline depth
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** complex_number_alu_core: PASSED **");
        end else begin
            $display("** complex_number_alu_core: FAILED **");
        end
        $finish;
    end

endmodule
